FILE: hw/rtl/sdl_pkg.sv
`timescale 1ns / 1ps

package sdl_pkg;

    localparam int ADDR_W      = 10;
    localparam int STORE_LEN   = 2 ** ADDR_W;
    localparam int LAT_CAP     = STORE_LEN - 1;
    localparam int SAMPLE_W    = 16;
    localparam int PAIR_W      = 2 * SAMPLE_W;
    localparam int FRAC_W      = 8;
    localparam int STEP_W      = 16;
    localparam int CFG_W       = 16;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + FRAC_W + 1;
    localparam int SHIFT_W     = PROD_W - FRAC_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ADDR_W-1:0]          addr_t;

    typedef enum logic [0:0] {
        CFG_TARGET = 1'b0,
        CFG_STEP   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_FWD,
        SRC_PREV,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        logic              vld;
        src_t              src_out;
        src_t              src_a;
        src_t              src_b;
        sample_t           fwd;
        sample_t           prv;
        logic [FRAC_W-1:0] frac;
        addr_t             lat;
    } rd_stage_t;

    function automatic sample_t pick(input src_t src, input sample_t mem_data,
                                     input sample_t fwd, input sample_t prv);
        sample_t res;
        case (src)
            SRC_MEM:  res = mem_data;
            SRC_FWD:  res = fwd;
            SRC_PREV: res = prv;
            SRC_ZERO: res = '0;
            default:  res = '0;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/sdl_ram.sv
`timescale 1ns / 1ps

module sdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/sdl_front.sv
`timescale 1ns / 1ps

module sdl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          advance,
    input  sdl_pkg::sample_t              in_sample,
    input  sdl_pkg::addr_t                tap_whole,
    input  logic [sdl_pkg::FRAC_W-1:0]    tap_frac,
    input  logic                          cfg_write,
    input  sdl_pkg::cfg_reg_t             cfg_sel,
    input  logic [sdl_pkg::CFG_W-1:0]     cfg_data,
    output sdl_pkg::rd_stage_t            rd_stage,
    output sdl_pkg::sample_t              d_out,
    output sdl_pkg::sample_t              d_a,
    output sdl_pkg::sample_t              d_b
);

    sdl_pkg::addr_t                 wp_reg, wp_next;
    sdl_pkg::addr_t                 lat_reg, lat_next;
    sdl_pkg::addr_t                 target_reg, target_next;
    logic [sdl_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [sdl_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic [sdl_pkg::ADDR_W:0]       fill_reg, fill_next;
    sdl_pkg::sample_t               prev_reg, prev_next;
    sdl_pkg::rd_stage_t             rd_reg, rd_next;

    logic [sdl_pkg::STEP_W-1:0]     step_eff;
    logic [sdl_pkg::STEP_W-1:0]     cnt_inc;
    sdl_pkg::addr_t                 idx_out;
    sdl_pkg::addr_t                 idx_a;
    sdl_pkg::addr_t                 idx_b;
    sdl_pkg::src_t                  src_b_c;
    sdl_pkg::sample_t               q_out;
    logic [sdl_pkg::PAIR_W-1:0]     q_pair;

    function automatic sdl_pkg::src_t classify(input sdl_pkg::addr_t idx,
                                               input sdl_pkg::addr_t wp,
                                               input logic [sdl_pkg::ADDR_W:0] fill);
        sdl_pkg::src_t res;
        if (idx == wp)
        begin
            res = sdl_pkg::SRC_FWD;
        end
        else if (fill[sdl_pkg::ADDR_W] || (idx < fill[sdl_pkg::ADDR_W-1:0]))
        begin
            res = sdl_pkg::SRC_MEM;
        end
        else
        begin
            res = sdl_pkg::SRC_ZERO;
        end
        return res;
    endfunction

    always_comb
    begin
        idx_out = wp_reg - lat_reg;
        idx_a   = wp_reg - tap_whole;
        idx_b   = idx_a - sdl_pkg::ADDR_W'(1);

        // The pair word at the write pointer is not yet stored, so the sample just
        // behind it comes from the register that holds the previous beat.
        if (idx_b == wp_reg)
        begin
            src_b_c = sdl_pkg::SRC_FWD;
        end
        else if (idx_a == wp_reg)
        begin
            src_b_c = sdl_pkg::SRC_PREV;
        end
        else
        begin
            src_b_c = classify(idx_b, wp_reg, fill_reg);
        end

        step_eff = (step_reg == '0) ? sdl_pkg::STEP_W'(1) : step_reg;
        cnt_inc  = cnt_reg + sdl_pkg::STEP_W'(1);

        wp_next     = wp_reg;
        lat_next    = lat_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        prev_next   = prev_reg;
        target_next = target_reg;
        step_next   = step_reg;

        if (accept)
        begin
            wp_next   = wp_reg + sdl_pkg::ADDR_W'(1);
            prev_next = in_sample;
            if (!fill_reg[sdl_pkg::ADDR_W])
            begin
                fill_next = fill_reg + (sdl_pkg::ADDR_W + 1)'(1);
            end
            if (target_reg != lat_reg)
            begin
                if (cnt_inc >= step_eff)
                begin
                    cnt_next = '0;
                    if (target_reg > lat_reg)
                    begin
                        lat_next = lat_reg + sdl_pkg::ADDR_W'(1);
                    end
                    else
                    begin
                        lat_next = lat_reg - sdl_pkg::ADDR_W'(1);
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
        end

        if (cfg_write)
        begin
            cnt_next = '0;
            case (cfg_sel)
                sdl_pkg::CFG_TARGET: target_next = cfg_data[sdl_pkg::ADDR_W-1:0];
                sdl_pkg::CFG_STEP:   step_next   = cfg_data[sdl_pkg::STEP_W-1:0];
                default:             target_next = target_reg;
            endcase
        end

        rd_next = rd_reg;
        if (advance)
        begin
            rd_next.vld     = accept;
            rd_next.src_out = classify(idx_out, wp_reg, fill_reg);
            rd_next.src_a   = classify(idx_a, wp_reg, fill_reg);
            rd_next.src_b   = src_b_c;
            rd_next.fwd     = in_sample;
            rd_next.prv     = prev_reg;
            rd_next.frac    = tap_frac;
            rd_next.lat     = lat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            lat_reg    <= '0;
            cnt_reg    <= '0;
            fill_reg   <= '0;
            prev_reg   <= '0;
            target_reg <= '0;
            step_reg   <= sdl_pkg::STEP_W'(1);
            rd_reg     <= '0;
        end
        else
        begin
            wp_reg     <= wp_next;
            lat_reg    <= lat_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
            prev_reg   <= prev_next;
            target_reg <= target_next;
            step_reg   <= step_next;
            rd_reg     <= rd_next;
        end
    end

    sdl_ram #(
        .WIDTH (sdl_pkg::SAMPLE_W),
        .DEPTH (sdl_pkg::STORE_LEN)
    ) u_ram_out (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (in_sample),
        .re    (advance),
        .raddr (idx_out),
        .rdata (q_out)
    );

    // Each word holds a sample together with the sample written just before it.
    sdl_ram #(
        .WIDTH (sdl_pkg::PAIR_W),
        .DEPTH (sdl_pkg::STORE_LEN)
    ) u_ram_tap (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata ({in_sample, prev_reg}),
        .re    (advance),
        .raddr (idx_a),
        .rdata (q_pair)
    );

    assign rd_stage = rd_reg;
    assign d_out    = q_out;
    assign d_a      = q_pair[sdl_pkg::PAIR_W-1:sdl_pkg::SAMPLE_W];
    assign d_b      = q_pair[sdl_pkg::SAMPLE_W-1:0];

endmodule

FILE: hw/rtl/sdl_interp.sv
`timescale 1ns / 1ps

module sdl_interp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  sdl_pkg::rd_stage_t   rd_stage,
    input  sdl_pkg::sample_t     d_out,
    input  sdl_pkg::sample_t     d_a,
    input  sdl_pkg::sample_t     d_b,
    output logic                 res_valid,
    output sdl_pkg::sample_t     res_out,
    output sdl_pkg::sample_t     res_tap,
    output sdl_pkg::addr_t       res_lat
);

    logic                               v2_reg, v2_next;
    sdl_pkg::sample_t                   out2_reg, out2_next;
    sdl_pkg::sample_t                   a2_reg, a2_next;
    logic signed [sdl_pkg::PROD_W-1:0]  prod2_reg, prod2_next;
    sdl_pkg::addr_t                     lat2_reg, lat2_next;

    logic                               v3_reg, v3_next;
    sdl_pkg::sample_t                   out3_reg, out3_next;
    sdl_pkg::sample_t                   tap3_reg, tap3_next;
    sdl_pkg::addr_t                     lat3_reg, lat3_next;

    sdl_pkg::sample_t                   a_s;
    sdl_pkg::sample_t                   b_s;
    logic signed [sdl_pkg::DIFF_W-1:0]  diff;
    logic signed [sdl_pkg::FRAC_W:0]    frac_s;
    logic signed [sdl_pkg::SHIFT_W-1:0] q_s;
    logic signed [sdl_pkg::SHIFT_W-1:0] sum_s;

    always_comb
    begin
        a_s    = sdl_pkg::pick(rd_stage.src_a, d_a, rd_stage.fwd, rd_stage.prv);
        b_s    = sdl_pkg::pick(rd_stage.src_b, d_b, rd_stage.fwd, rd_stage.prv);
        diff   = sdl_pkg::DIFF_W'(b_s) - sdl_pkg::DIFF_W'(a_s);
        frac_s = $signed({1'b0, rd_stage.frac});

        v2_next    = v2_reg;
        out2_next  = out2_reg;
        a2_next    = a2_reg;
        prod2_next = prod2_reg;
        lat2_next  = lat2_reg;
        if (advance)
        begin
            v2_next    = rd_stage.vld;
            out2_next  = sdl_pkg::pick(rd_stage.src_out, d_out, rd_stage.fwd, rd_stage.prv);
            a2_next    = a_s;
            prod2_next = sdl_pkg::PROD_W'(diff) * sdl_pkg::PROD_W'(frac_s);
            lat2_next  = rd_stage.lat;
        end

        q_s   = sdl_pkg::SHIFT_W'(prod2_reg >>> sdl_pkg::FRAC_W);
        sum_s = sdl_pkg::SHIFT_W'(a2_reg) + q_s;

        v3_next   = v3_reg;
        out3_next = out3_reg;
        tap3_next = tap3_reg;
        lat3_next = lat3_reg;
        if (advance)
        begin
            v3_next   = v2_reg;
            out3_next = out2_reg;
            tap3_next = sum_s[sdl_pkg::SAMPLE_W-1:0];
            lat3_next = lat2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out2_reg  <= out2_next;
        a2_reg    <= a2_next;
        prod2_reg <= prod2_next;
        lat2_reg  <= lat2_next;
        out3_reg  <= out3_next;
        tap3_reg  <= tap3_next;
        lat3_reg  <= lat3_next;
    end

    assign res_valid = v3_reg;
    assign res_out   = out3_reg;
    assign res_tap   = tap3_reg;
    assign res_lat   = lat3_reg;

endmodule

FILE: hw/rtl/slewed_delay_line.sv
`timescale 1ns / 1ps
// A result beat passes through the read stage register, then the product and result stage registers.
// One beat per cycle when not stalled; each item reads the sample and pair memories once.
// The pipeline stalls as a whole only while the output register holds an untaken beat.
// Reset clears pointers, latency, chase counter, target and valid flags at once; a fill count
// makes never-written store entries read as zero, so no clearing pass is needed.

module slewed_delay_line (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [15:0]           in_sample,
    input  logic [9:0]                   tap_whole,
    input  logic [7:0]                   tap_frac,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           out_sample,
    output logic signed [15:0]           tap_sample,
    output logic [9:0]                   current_latency,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [15:0]                  cfg_data
);

    logic                advance;
    logic                accept;
    logic                res_valid;
    sdl_pkg::rd_stage_t  rd_stage;
    sdl_pkg::sample_t    d_out;
    sdl_pkg::sample_t    d_a;
    sdl_pkg::sample_t    d_b;
    sdl_pkg::sample_t    res_out;
    sdl_pkg::sample_t    res_tap;
    sdl_pkg::addr_t      res_lat;

    assign advance   = !(res_valid && !out_ready);
    assign in_ready  = advance;
    assign accept    = in_valid && advance;
    assign cfg_ready = 1'b1;

    sdl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .in_sample (in_sample),
        .tap_whole (tap_whole),
        .tap_frac  (tap_frac),
        .cfg_write (cfg_valid),
        .cfg_sel   (sdl_pkg::cfg_reg_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .rd_stage  (rd_stage),
        .d_out     (d_out),
        .d_a       (d_a),
        .d_b       (d_b)
    );

    sdl_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rd_stage  (rd_stage),
        .d_out     (d_out),
        .d_a       (d_a),
        .d_b       (d_b),
        .res_valid (res_valid),
        .res_out   (res_out),
        .res_tap   (res_tap),
        .res_lat   (res_lat)
    );

    assign out_valid       = res_valid;
    assign out_sample      = res_out;
    assign tap_sample      = res_tap;
    assign current_latency = res_lat;

endmodule

FILE: tb/sv/tb_slewed_delay_line.sv
`timescale 1ns / 1ps

module tb_slewed_delay_line;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 6;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        sdl_pkg::sample_t smp;
        sdl_pkg::sample_t tap;
        sdl_pkg::addr_t   lat;
    } tap_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    sdl_pkg::sample_t           in_sample;
    sdl_pkg::addr_t             tap_whole;
    logic [sdl_pkg::FRAC_W-1:0] tap_frac;
    logic                       out_valid;
    logic                       out_ready;
    sdl_pkg::sample_t           out_sample;
    sdl_pkg::sample_t           tap_sample;
    sdl_pkg::addr_t             current_latency;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [0:0]                 cfg_index;
    logic [sdl_pkg::CFG_W-1:0]  cfg_data;

    sdl_pkg::sample_t           line_mem [sdl_pkg::STORE_LEN];
    sdl_pkg::addr_t             wr_ptr;
    sdl_pkg::addr_t             lat_now;
    logic [sdl_pkg::STEP_W-1:0] chase_cnt;
    sdl_pkg::addr_t             tgt_reg;
    logic [sdl_pkg::STEP_W-1:0] step_reg;

    tap_result_t       due_taps [$];
    bit                src_idle_en;
    bit                sink_idle_en;
    bit                hold_go;
    int                cycle_cnt = 0;
    int                n_items = 0;
    int                n_checked = 0;
    int                n_cfg = 0;
    int                n_errors = 0;
    int                max_lat_seen = 0;

    slewed_delay_line dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_sample       (in_sample),
        .tap_whole       (tap_whole),
        .tap_frac        (tap_frac),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_sample      (out_sample),
        .tap_sample      (tap_sample),
        .current_latency (current_latency),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_cnt, due_taps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic compute_delay_taps(input sdl_pkg::sample_t smp, input sdl_pkg::addr_t whole,
                                      input logic [sdl_pkg::FRAC_W-1:0] frac);
        tap_result_t                r;
        sdl_pkg::addr_t             idx;
        sdl_pkg::sample_t           near_s;
        sdl_pkg::sample_t           far_s;
        logic signed [16:0]         diff;
        logic signed [26:0]         prod;
        logic [sdl_pkg::STEP_W-1:0] pace;
        line_mem[wr_ptr] = smp;
        idx = wr_ptr - lat_now;
        r.smp = line_mem[idx];
        idx = wr_ptr - whole;
        near_s = line_mem[idx];
        idx = idx - sdl_pkg::addr_t'(1);
        far_s = line_mem[idx];
        diff = 17'(far_s) - 17'(near_s);
        prod = 27'(diff) * 27'($signed({1'b0, frac}));
        r.tap = sdl_pkg::sample_t'(27'(near_s) + (prod >>> sdl_pkg::FRAC_W));
        r.lat = lat_now;
        due_taps.push_back(r);
        if (int'(lat_now) > max_lat_seen)
            max_lat_seen = int'(lat_now);
        pace = (step_reg == 0) ? 16'd1 : step_reg;
        if (tgt_reg != lat_now)
        begin
            chase_cnt = chase_cnt + 16'd1;
            if (chase_cnt >= pace)
            begin
                if (tgt_reg > lat_now)
                    lat_now = lat_now + sdl_pkg::addr_t'(1);
                else
                    lat_now = lat_now - sdl_pkg::addr_t'(1);
                chase_cnt = '0;
            end
        end
        wr_ptr = wr_ptr + sdl_pkg::addr_t'(1);
    endtask

    task automatic send_item(input sdl_pkg::sample_t smp, input sdl_pkg::addr_t whole,
                             input logic [sdl_pkg::FRAC_W-1:0] frac);
        int gap;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 3) == 0)
            gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= smp;
        tap_whole <= whole;
        tap_frac  <= frac;
        do
            @(posedge clk);
        while (!in_ready);
        compute_delay_taps(smp, whole, frac);
        n_items++;
    endtask

    task automatic send_random_item();
        sdl_pkg::sample_t           smp;
        sdl_pkg::addr_t             whole;
        logic [sdl_pkg::FRAC_W-1:0] frac;
        int                         r;
        smp = sdl_pkg::sample_t'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            smp = 16'sh7FFF;
        else if (r == 1)
            smp = 16'sh8000;
        r = $urandom_range(0, 9);
        if (r < 6)
            whole = sdl_pkg::addr_t'($urandom);
        else if (r < 8)
            whole = lat_now + sdl_pkg::addr_t'($urandom_range(0, 4)) - sdl_pkg::addr_t'(2);
        else
        begin
            case ($urandom_range(0, 3))
                0:       whole = 10'd0;
                1:       whole = 10'd1;
                2:       whole = 10'd1022;
                default: whole = 10'd1023;
            endcase
        end
        frac = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            frac = 8'd0;
        else if (r == 1)
            frac = 8'd255;
        send_item(smp, whole, frac);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (due_taps.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (due_taps.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, due_taps.size());
            n_errors++;
            due_taps.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_chase(input logic [sdl_pkg::CFG_W-1:0] tgt_data,
                             input logic [sdl_pkg::CFG_W-1:0] step_data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= sdl_pkg::CFG_TARGET;
        cfg_data  <= tgt_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tgt_reg = tgt_data[sdl_pkg::ADDR_W-1:0];
        chase_cnt = '0;
        cfg_index <= sdl_pkg::CFG_STEP;
        cfg_data  <= step_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        step_reg = step_data;
        chase_cnt = '0;
        cfg_valid <= 1'b0;
        n_cfg += 2;
    endtask

    task automatic compare_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : check_outputs
        tap_result_t due;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (due_taps.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result beat, expected none, actual %0d/%0d/%0d",
                         $time, out_sample, tap_sample, current_latency);
            end
            else
            begin
                due = due_taps.pop_front();
                compare_field("out_sample", int'(due.smp), int'(out_sample));
                compare_field("tap_sample", int'(due.tap), int'(tap_sample));
                compare_field("current_latency", int'(due.lat), int'(current_latency));
                n_checked++;
            end
        end
    end

    initial
    begin : drive_sink
        int hold_left;
        int stall_left;
        bit hold_taken;
        hold_left = 0;
        stall_left = 0;
        hold_taken = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = gap_len() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_directed_edges();
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        send_item(16'sh7FFF, 10'd0, 8'd0);
        send_item(16'sh8000, 10'd0, 8'd255);
        send_item(-16'sd1, 10'd0, 8'd128);
        send_item(16'sd0, 10'd1, 8'd255);
        send_item(16'sd1, 10'd1, 8'd1);
        send_item(16'sd12345, 10'd1023, 8'd0);
        send_item(-16'sd12345, 10'd1023, 8'd255);
        send_item(16'sh5555, 10'd1022, 8'd200);
        send_item(16'shAAAA, 10'd2, 8'd128);
        send_item(16'sd100, 10'd1, 8'd3);
        set_chase(16'hFFFF, 16'd0);
        repeat (6) send_random_item();
        set_chase(16'hFC03, 16'hFFFF);
        repeat (4) send_random_item();
        set_chase(16'h0000, 16'd2);
        repeat (5) send_random_item();
    endtask

    task automatic random_phase(input int count, input logic [sdl_pkg::CFG_W-1:0] tgt_data,
                                input logic [sdl_pkg::CFG_W-1:0] step_data,
                                input bit src_idle, input bit sink_idle);
        set_chase(tgt_data, step_data);
        src_idle_en = src_idle;
        sink_idle_en <= sink_idle;
        repeat (count) send_random_item();
    endtask

    task automatic test_random_chase();
        logic [sdl_pkg::CFG_W-1:0] d;
        d = 16'($urandom);
        random_phase(150, d, 16'd1, 1'b0, 1'b0);
        d = 16'($urandom);
        d[sdl_pkg::ADDR_W-1:0] = 10'd1023;
        random_phase(300, d, 16'd0, 1'b1, 1'b1);
        random_phase(200, 16'($urandom), 16'($urandom_range(0, 3)), 1'b1, 1'b1);
        random_phase(150, 16'($urandom), 16'hFFFF, 1'b1, 1'b0);
        random_phase(150, 16'h0000, 16'($urandom_range(1, 8)), 1'b0, 1'b1);
        random_phase(150, 16'($urandom), 16'($urandom), 1'b1, 1'b1);
    endtask

    task automatic test_output_hold();
        set_chase(16'($urandom), 16'($urandom_range(0, 2)));
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        hold_go = 1'b1;
        repeat (60) send_random_item();
        wait_drained();
        src_idle_en = 1'b1;
        sink_idle_en <= 1'b1;
        repeat (40) send_random_item();
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_sample   <= '0;
        tap_whole   <= '0;
        tap_frac    <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= sdl_pkg::CFG_TARGET;
        cfg_data    <= '0;
        hold_go     = 1'b0;
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        for (int i = 0; i < sdl_pkg::STORE_LEN; i++)
            line_mem[i] = '0;
        wr_ptr    = '0;
        lat_now   = '0;
        chase_cnt = '0;
        tgt_reg   = '0;
        step_reg  = 16'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_random_chase();
        test_output_hold();
        wait_drained();
        $display("Sent %0d sample beats, checked %0d results, made %0d register writes.",
                 n_items, n_checked, n_cfg);
        $display("Latency chased up to %0d samples; taps spanned the store with wrap-around.",
                 max_lat_seen);
        if (n_errors == 0 && due_taps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
